// ===== design/acl_pkg.sv =====
// Package for the IPv4 ACL classifier: rule codes, configuration record,
// header offsets and protocol constants. No dependencies.
`default_nettype none

package acl_pkg;

    // Rule codes 0 to 7 in the order the rule list is evaluated; RULE_PASS is checked before them all
    typedef enum logic [3:0] {
        RULE_TRUSTED   = 4'd0,
        RULE_BLOCK_NET = 4'd1,
        RULE_SSH_BLOCK = 4'd2,
        RULE_TCP_OK    = 4'd3,
        RULE_TCP_DROP  = 4'd4,
        RULE_UDP_OK    = 4'd5,
        RULE_ICMP      = 4'd6,
        RULE_DEFAULT   = 4'd7,
        RULE_PASS      = 4'd8
    } t_rule;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUSTED_SOURCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_NET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SSH_BLOCK_NET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SSH_BLOCK_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SSH_PORT       = 3'd5;

    typedef struct packed {
        logic [31:0] trusted_source;
        logic [31:0] blocked_net;
        logic [31:0] blocked_mask;
        logic [31:0] ssh_block_net;
        logic [31:0] ssh_block_mask;
        logic [15:0] ssh_port;
    } t_acl_cfg;

    localparam t_acl_cfg CFG_RESET = '{
        trusted_source: 32'h0A08_32B4,
        blocked_net:    32'hC0A8_6400,
        blocked_mask:   32'hFFFF_FF00,
        ssh_block_net:  32'h0A00_0000,
        ssh_block_mask: 32'hFF00_0000,
        ssh_port:       16'd22
    };

    // Byte position counter: saturates well above every offset that matters
    localparam int unsigned   POS_W   = 7;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Header byte offsets from the destination MAC
    localparam logic [POS_W-1:0] OFS_ETH_HI = 7'd12;
    localparam logic [POS_W-1:0] OFS_ETH_LO = 7'd13;
    localparam logic [POS_W-1:0] OFS_IHL    = 7'd14;
    localparam logic [POS_W-1:0] OFS_PROTO  = 7'd23;
    localparam logic [POS_W-1:0] OFS_SRC    = 7'd26;
    localparam logic [POS_W-1:0] OFS_SRC_LAST = 7'd29;

    // Length thresholds (frame length is one bit wider than the position)
    localparam logic [POS_W:0] MIN_IPV4_LEN = 8'd34;
    localparam logic [POS_W:0] TCP_HDR_LEN  = 8'd20;
    localparam logic [POS_W:0] UDP_HDR_LEN  = 8'd8;

    localparam logic [7:0] ETYPE_HI = 8'h08;
    localparam logic [7:0] ETYPE_LO = 8'h00;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [15:0] PORT_DNS   = 16'd53;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_PERF  = 16'd5201;
    localparam logic [15:0] PORT_U5001 = 16'd5001;
    localparam logic [15:0] PORT_U5500 = 16'd5500;
    localparam logic [15:0] PORT_U9900 = 16'd9900;

    // Verdict queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Drop rules
    function automatic logic rule_is_drop(input t_rule rule);
        return (rule == RULE_BLOCK_NET) || (rule == RULE_SSH_BLOCK) ||
               (rule == RULE_TCP_DROP)  || (rule == RULE_DEFAULT);
    endfunction

    // Ports accepted for TCP in either direction
    function automatic logic is_web_port(input logic [15:0] port);
        return (port == PORT_HTTP) || (port == PORT_HTTPS) || (port == PORT_PERF);
    endfunction

    // Destination ports accepted for UDP
    function automatic logic is_udp_service(input logic [15:0] port);
        return (port == PORT_DNS) || (port == PORT_U5001) || (port == PORT_HTTP) ||
               (port == PORT_U5500) || (port == PORT_U9900);
    endfunction

endpackage

`default_nettype wire

// ===== design/ipv4_packet_acl_classifier.sv =====
// Top level of the IPv4 ACL classifier: configuration registers, front end,
// verdict queue and counter back end. Uses acl_pkg, acl_parse, acl_queue, acl_count.
//
// Frame bytes enter one per cycle, first byte the destination MAC, with the
// last byte flagged; every byte is a transfer of its own and the block takes one
// each cycle. Header fields (ethertype, ihl, protocol, IPv4 source, TCP/UDP
// ports) are captured as they pass, so no header buffer is kept and no clearing
// pass follows reset. On the last byte the rule list is evaluated in that same
// cycle and the verdict enters a four-entry queue; the counter stage then
// registers it in its output register, carrying the accept and drop totals
// after that frame. The input stalls only while the queue is full, i.e.
// when four verdicts wait behind a stalled output. Configuration writes are
// always ready and take effect on the next frame decision.
`default_nettype none

module ipv4_packet_acl_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // frame byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_frame_byte,
    input  logic                          i_end_of_frame,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_verdict,
    output logic                          o_was_counted,
    output logic [3:0]                    o_rule_hit,
    output logic [63:0]                   o_accepted_total,
    output logic [63:0]                   o_dropped_total,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [acl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import acl_pkg::*;

    t_acl_cfg r_cfg;
    logic     push;
    t_rule    push_rule;
    logic     pop;
    logic     q_not_empty;
    logic     q_full;
    t_rule    q_rule;

    // Configuration registers; writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TRUSTED_SOURCE: r_cfg.trusted_source <= i_cfg_data;
                CFG_BLOCKED_NET:    r_cfg.blocked_net    <= i_cfg_data;
                CFG_BLOCKED_MASK:   r_cfg.blocked_mask   <= i_cfg_data;
                CFG_SSH_BLOCK_NET:  r_cfg.ssh_block_net  <= i_cfg_data;
                CFG_SSH_BLOCK_MASK: r_cfg.ssh_block_mask <= i_cfg_data;
                CFG_SSH_PORT:       r_cfg.ssh_port       <= i_cfg_data[15:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    acl_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_cfg          (r_cfg),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_rule         (push_rule)
    );

    acl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rule      (push_rule),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_full      (q_full),
        .o_rule      (q_rule)
    );

    acl_count u_count (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_not_empty    (q_not_empty),
        .i_q_rule         (q_rule),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_verdict        (o_verdict),
        .o_was_counted    (o_was_counted),
        .o_rule_hit       (o_rule_hit),
        .o_accepted_total (o_accepted_total),
        .o_dropped_total  (o_dropped_total)
    );

endmodule

`default_nettype wire

// ===== design/acl_parse.sv =====
// Front end of the ACL classifier: takes frame bytes, captures the header
// fields on the fly and evaluates the rule list on the last byte. Uses acl_pkg.
`default_nettype none

module acl_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_end_of_frame,
    input  acl_pkg::t_acl_cfg i_cfg,
    input  logic              i_queue_full,
    output logic              o_push,
    output acl_pkg::t_rule    o_rule
);
    import acl_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_eth_hi_ok;
    logic             r_is_ipv4;
    logic [POS_W-1:0] r_l4;
    logic [7:0]       r_proto;
    logic [31:0]      r_src;
    logic [15:0]      r_sport;
    logic [15:0]      r_dport;

    logic             accept;
    logic [POS_W-1:0] l4_now;
    logic [POS_W-1:0] l4_eff;
    logic             past_ihl;
    logic [POS_W:0]   frame_len;
    logic             is_tcp;
    logic             is_udp;
    t_rule            rule;

    // Stall only when the verdict queue cannot take another entry
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;

    // L4 offset from the ihl nibble; the byte at offset 14 may itself be a port byte
    assign l4_now   = OFS_IHL + {1'b0, i_frame_byte[3:0], 2'b00};
    assign l4_eff   = (r_pos == OFS_IHL) ? l4_now : r_l4;
    assign past_ihl = (r_pos >= OFS_IHL);

    // Advance the byte position, saturating; restart on the last byte
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_end_of_frame) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Capture header fields as their bytes go past
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_pos == OFS_ETH_HI) begin
                r_eth_hi_ok <= (i_frame_byte == ETYPE_HI);
            end
            if (r_pos == OFS_ETH_LO) begin
                r_is_ipv4 <= r_eth_hi_ok && (i_frame_byte == ETYPE_LO);
            end
            if (r_pos == OFS_IHL) begin
                r_l4 <= l4_now;
            end
            if (r_pos == OFS_PROTO) begin
                r_proto <= i_frame_byte;
            end
            if (r_pos >= OFS_SRC && r_pos <= OFS_SRC_LAST) begin
                r_src <= {r_src[23:0], i_frame_byte};
            end
            if (past_ihl) begin
                if (r_pos == l4_eff) begin
                    r_sport[15:8] <= i_frame_byte;
                end
                if (r_pos == l4_eff + 7'd1) begin
                    r_sport[7:0] <= i_frame_byte;
                end
                if (r_pos == l4_eff + 7'd2) begin
                    r_dport[15:8] <= i_frame_byte;
                end
                if (r_pos == l4_eff + 7'd3) begin
                    r_dport[7:0] <= i_frame_byte;
                end
            end
        end
    end

    // Evaluate the rule list; all fields it reads lie before the last byte
    assign frame_len = {1'b0, r_pos} + 1'b1;
    assign is_tcp    = (r_proto == PROTO_TCP);
    assign is_udp    = (r_proto == PROTO_UDP);

    always_comb begin
        priority if (frame_len < MIN_IPV4_LEN || !r_is_ipv4) begin
            rule = RULE_PASS;
        end else if (is_tcp && ({1'b0, r_l4} + TCP_HDR_LEN > frame_len)) begin
            rule = RULE_PASS;
        end else if (is_udp && ({1'b0, r_l4} + UDP_HDR_LEN > frame_len)) begin
            rule = RULE_PASS;
        end else if (is_tcp && r_src == i_cfg.trusted_source &&
                     r_dport == i_cfg.ssh_port) begin
            rule = RULE_TRUSTED;
        end else if ((r_src & i_cfg.blocked_mask) == i_cfg.blocked_net) begin
            rule = RULE_BLOCK_NET;
        end else if (is_tcp && r_dport == i_cfg.ssh_port &&
                     (r_src & i_cfg.ssh_block_mask) == i_cfg.ssh_block_net) begin
            rule = RULE_SSH_BLOCK;
        end else if (is_tcp) begin
            rule = (is_web_port(r_dport) || is_web_port(r_sport)) ?
                   RULE_TCP_OK : RULE_TCP_DROP;
        end else if (is_udp && is_udp_service(r_dport)) begin
            rule = RULE_UDP_OK;
        end else if (r_proto == PROTO_ICMP) begin
            rule = RULE_ICMP;
        end else begin
            rule = RULE_DEFAULT;
        end
    end

    // Hand one verdict per frame to the queue
    assign o_push = accept && i_end_of_frame;
    assign o_rule = rule;

    // A frame's last byte always restarts the position count
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == '0))
        else $error("byte position not cleared after last byte");

endmodule

`default_nettype wire

// ===== design/acl_queue.sv =====
// Short verdict queue between the classifier front end and the counter back
// end. Uses acl_pkg for the rule type and depth.
`default_nettype none

module acl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acl_pkg::t_rule i_rule,
    input  logic           i_pop,
    output logic           o_not_empty,
    output logic           o_full,
    output acl_pkg::t_rule o_rule
);
    import acl_pkg::*;

    t_rule               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rule;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_rule      = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("verdict queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("verdict queue read while empty");

endmodule

`default_nettype wire

// ===== design/acl_count.sv =====
// Back end of the ACL classifier: takes verdicts from the queue, bumps the
// accept and drop counters and holds the result for transfer. Uses acl_pkg.
`default_nettype none

module acl_count (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_not_empty,
    input  acl_pkg::t_rule i_q_rule,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_verdict,
    output logic           o_was_counted,
    output logic [3:0]     o_rule_hit,
    output logic [63:0]    o_accepted_total,
    output logic [63:0]    o_dropped_total
);
    import acl_pkg::*;

    logic        r_out_valid;
    t_rule       r_rule;
    logic        r_verdict;
    logic        r_counted;
    logic [63:0] r_acc;
    logic [63:0] r_drp;

    logic        is_drop;
    logic        counted;

    // Take a verdict when the output register is free or being emptied
    assign o_pop   = i_q_not_empty && (!r_out_valid || !i_out_stall);
    assign is_drop = rule_is_drop(i_q_rule);
    assign counted = (i_q_rule != RULE_PASS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_drp       <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (counted && is_drop) begin
                    r_drp <= r_drp + 64'd1;
                end
                if (counted && !is_drop) begin
                    r_acc <= r_acc + 64'd1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result fields alongside the counters
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rule    <= i_q_rule;
            r_verdict <= is_drop;
            r_counted <= counted;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_was_counted    = r_counted;
    assign o_rule_hit       = r_rule;
    assign o_accepted_total = r_acc;
    assign o_dropped_total  = r_drp;

    a_drop_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && counted && is_drop) |=> (r_drp == $past(r_drp) + 64'd1) &&
                                          (r_acc == $past(r_acc)))
        else $error("drop counter did not advance on a drop verdict");

    a_counted_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_counted == (r_rule != RULE_PASS)))
        else $error("counted flag disagrees with rule code");

endmodule

`default_nettype wire
